// ===== rtl/icac_pkg.sv =====
// Shared types and constants for the incubator climate alarm controller.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package icac_pkg;

	localparam int unsigned TEMP_W = 8;
	localparam int unsigned HUM_W  = 7;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;

	// Fixed humidity critical bounds in percent.
	localparam logic [HUM_W-1:0] HUM_CRITICAL_HIGH = 7'd80;
	localparam logic [HUM_W-1:0] HUM_CRITICAL_LOW  = 7'd40;

	// Register indexes (byte address divided by four).
	localparam logic [2:0] REG_TEMP_HIGH  = 3'd0;
	localparam logic [2:0] REG_TEMP_LOW   = 3'd1;
	localparam logic [2:0] REG_TEMP_CHIGH = 3'd2;
	localparam logic [2:0] REG_TEMP_CLOW  = 3'd3;
	localparam logic [2:0] REG_HUM_HIGH   = 3'd4;
	localparam logic [2:0] REG_HUM_LOW    = 3'd5;
	localparam logic [2:0] REG_ALARM_DLY  = 3'd6;
	localparam logic [2:0] REG_CRIT_DLY   = 3'd7;

	// Alarm levels.
	localparam logic [1:0] LVL_NONE     = 2'd0;
	localparam logic [1:0] LVL_ALARM    = 2'd1;
	localparam logic [1:0] LVL_CRITICAL = 2'd2;

	// Alarm events.
	localparam logic [2:0] EV_NONE           = 3'd0;
	localparam logic [2:0] EV_ALARM          = 3'd1;
	localparam logic [2:0] EV_CRITICAL       = 3'd2;
	localparam logic [2:0] EV_RECOVERED      = 3'd3;
	localparam logic [2:0] EV_RECOVERED_CRIT = 3'd4;

	typedef struct packed {
		logic [TEMP_W-1:0] temp_high_limit;
		logic [TEMP_W-1:0] temp_low_limit;
		logic [TEMP_W-1:0] temp_critical_high;
		logic [TEMP_W-1:0] temp_critical_low;
		logic [HUM_W-1:0]  hum_high_limit;
		logic [HUM_W-1:0]  hum_low_limit;
		logic [TIME_W-1:0] alarm_delay_ms;
		logic [TIME_W-1:0] critical_delay_ms;
	} cfg_t;

	typedef struct packed {
		logic [TEMP_W-1:0] temperature;
		logic [HUM_W-1:0]  humidity;
		logic [TIME_W-1:0] now_ms;
	} sample_t;

	typedef struct packed {
		logic       lamp_on;
		logic       cooler_on;
		logic       humidifier_on;
		logic       buzzer_on;
		logic       critical_alert;
		logic [1:0] temp_alarm_level;
		logic [1:0] hum_alarm_level;
		logic [2:0] temp_event;
		logic [2:0] hum_event;
	} result_t;

	// Buzzer control from one alarm timer.
	typedef struct packed {
		logic raised;
		logic recovered;
	} alarm_stat_t;

endpackage

`default_nettype wire

// ===== rtl/icac_regs.sv =====
// APB-style configuration registers of the incubator climate alarm controller.
// Depends on icac_pkg for the register indexes and the cfg_t layout.
`default_nettype none

module icac_regs
	import icac_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign idx    = paddr[ADDR_W-1:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.temp_high_limit    <= 8'd38;
			cfg_q.temp_low_limit     <= 8'd37;
			cfg_q.temp_critical_high <= 8'd40;
			cfg_q.temp_critical_low  <= 8'd35;
			cfg_q.hum_high_limit     <= 7'd65;
			cfg_q.hum_low_limit      <= 7'd55;
			cfg_q.alarm_delay_ms     <= 32'd600000;
			cfg_q.critical_delay_ms  <= 32'd1800000;
		end else if (wr_en) begin
			case (idx)
				REG_TEMP_HIGH:  cfg_q.temp_high_limit    <= pwdata[TEMP_W-1:0];
				REG_TEMP_LOW:   cfg_q.temp_low_limit     <= pwdata[TEMP_W-1:0];
				REG_TEMP_CHIGH: cfg_q.temp_critical_high <= pwdata[TEMP_W-1:0];
				REG_TEMP_CLOW:  cfg_q.temp_critical_low  <= pwdata[TEMP_W-1:0];
				REG_HUM_HIGH:   cfg_q.hum_high_limit     <= pwdata[HUM_W-1:0];
				REG_HUM_LOW:    cfg_q.hum_low_limit      <= pwdata[HUM_W-1:0];
				REG_ALARM_DLY:  cfg_q.alarm_delay_ms     <= pwdata[TIME_W-1:0];
				REG_CRIT_DLY:   cfg_q.critical_delay_ms  <= pwdata[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_TEMP_HIGH:  prdata = {24'd0, cfg_q.temp_high_limit};
			REG_TEMP_LOW:   prdata = {24'd0, cfg_q.temp_low_limit};
			REG_TEMP_CHIGH: prdata = {24'd0, cfg_q.temp_critical_high};
			REG_TEMP_CLOW:  prdata = {24'd0, cfg_q.temp_critical_low};
			REG_HUM_HIGH:   prdata = {25'd0, cfg_q.hum_high_limit};
			REG_HUM_LOW:    prdata = {25'd0, cfg_q.hum_low_limit};
			REG_ALARM_DLY:  prdata = cfg_q.alarm_delay_ms;
			REG_CRIT_DLY:   prdata = cfg_q.critical_delay_ms;
			default:        prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/icac_alarm.sv =====
// Two-stage alarm timer for one measured quantity: level, timestamp and event.
// Depends on icac_pkg for level and event codes.
`default_nettype none

module icac_alarm
	import icac_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              upd,
	input  wire logic              in_range,
	input  wire logic [TIME_W-1:0] now_ms,
	input  wire logic [TIME_W-1:0] alarm_delay_ms,
	input  wire logic [TIME_W-1:0] critical_delay_ms,
	output logic      [1:0]        level,
	output logic      [2:0]        event_code,
	output alarm_stat_t            stat
);

	logic [1:0]        level_q;
	logic [TIME_W-1:0] since_q;
	logic [TIME_W-1:0] elapsed;
	logic              past_alarm;
	logic              past_crit;
	logic [1:0]        level_n;
	logic [2:0]        ev_n;

	// A return to range restarts the timer at now, and no escalation can happen
	// in the same sample, since past_alarm needs the quantity out of range.
	assign elapsed    = now_ms - since_q;
	assign past_alarm = !in_range && (elapsed > alarm_delay_ms);
	assign past_crit  = elapsed > critical_delay_ms;

	always_comb begin
		level_n        = level_q;
		ev_n           = EV_NONE;
		stat.raised    = 1'b0;
		stat.recovered = 1'b0;
		if (in_range) begin
			stat.recovered = 1'b1;
			level_n        = LVL_NONE;
			if (level_q == LVL_ALARM) begin
				ev_n = EV_RECOVERED;
			end else if (level_q == LVL_CRITICAL) begin
				ev_n = EV_RECOVERED_CRIT;
			end
		end else if (past_alarm) begin
			if (level_q == LVL_NONE) begin
				level_n     = LVL_ALARM;
				ev_n        = EV_ALARM;
				stat.raised = 1'b1;
			end else if (level_q == LVL_ALARM && past_crit) begin
				level_n = LVL_CRITICAL;
				ev_n    = EV_CRITICAL;
			end
		end
	end

	assign level      = level_n;
	assign event_code = ev_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= LVL_NONE;
			since_q <= '1;
		end else if (upd) begin
			level_q <= level_n;
			if (in_range) begin
				since_q <= now_ms;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/icac_ctrl.sv =====
// Actuator control with hysteresis, critical flag and the two alarm timers.
// Depends on icac_pkg and instantiates icac_alarm twice.
`default_nettype none

module icac_ctrl
	import icac_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    upd,
	input  wire cfg_t    cfg,
	input  wire sample_t smp,
	output result_t      res
);

	logic        lamp_q, cooler_q, humid_q, buzzer_q;
	logic        lamp_n, cooler_n, humid_n, buzzer_n;
	logic        t_hi, t_lo, h_hi, h_lo;
	logic        crit;
	alarm_stat_t t_stat, h_stat;
	logic [1:0]  t_level, h_level;
	logic [2:0]  t_ev, h_ev;

	assign t_hi = smp.temperature > cfg.temp_high_limit;
	assign t_lo = !t_hi && (smp.temperature < cfg.temp_low_limit);
	assign h_hi = smp.humidity > cfg.hum_high_limit;
	assign h_lo = !h_hi && (smp.humidity < cfg.hum_low_limit);

	assign crit = (t_hi && (smp.temperature > cfg.temp_critical_high))
		|| (t_lo && (smp.temperature < cfg.temp_critical_low))
		|| (h_hi && (smp.humidity > HUM_CRITICAL_HIGH))
		|| (h_lo && (smp.humidity < HUM_CRITICAL_LOW));

	// The humidity side may override the cooler only where temperature allows.
	always_comb begin
		lamp_n   = lamp_q;
		cooler_n = cooler_q;
		humid_n  = humid_q;
		if (t_hi) begin
			lamp_n   = 1'b0;
			cooler_n = 1'b1;
		end else if (t_lo) begin
			lamp_n   = 1'b1;
			cooler_n = 1'b0;
		end
		if (h_hi) begin
			humid_n = 1'b0;
			if (smp.temperature > cfg.temp_low_limit) begin
				cooler_n = 1'b1;
			end
		end else if (h_lo) begin
			humid_n = 1'b1;
			if (smp.temperature < cfg.temp_high_limit) begin
				cooler_n = 1'b0;
			end
		end
	end

	// A new alarm wins over any recovery in the same sample.
	always_comb begin
		buzzer_n = buzzer_q;
		if (t_stat.raised || h_stat.raised) begin
			buzzer_n = 1'b1;
		end else if (t_stat.recovered || h_stat.recovered) begin
			buzzer_n = 1'b0;
		end
	end

	icac_alarm u_temp_alarm (
		.clk               (clk),
		.arst_n            (arst_n),
		.upd               (upd),
		.in_range          (!t_hi && !t_lo),
		.now_ms            (smp.now_ms),
		.alarm_delay_ms    (cfg.alarm_delay_ms),
		.critical_delay_ms (cfg.critical_delay_ms),
		.level             (t_level),
		.event_code        (t_ev),
		.stat              (t_stat)
	);

	icac_alarm u_hum_alarm (
		.clk               (clk),
		.arst_n            (arst_n),
		.upd               (upd),
		.in_range          (!h_hi && !h_lo),
		.now_ms            (smp.now_ms),
		.alarm_delay_ms    (cfg.alarm_delay_ms),
		.critical_delay_ms (cfg.critical_delay_ms),
		.level             (h_level),
		.event_code        (h_ev),
		.stat              (h_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lamp_q   <= 1'b0;
			cooler_q <= 1'b0;
			humid_q  <= 1'b0;
			buzzer_q <= 1'b0;
		end else if (upd) begin
			lamp_q   <= lamp_n;
			cooler_q <= cooler_n;
			humid_q  <= humid_n;
			buzzer_q <= buzzer_n;
		end
	end

	assign res.lamp_on          = lamp_n;
	assign res.cooler_on        = cooler_n;
	assign res.humidifier_on    = humid_n;
	assign res.buzzer_on        = buzzer_n;
	assign res.critical_alert   = crit;
	assign res.temp_alarm_level = t_level;
	assign res.hum_alarm_level  = h_level;
	assign res.temp_event       = t_ev;
	assign res.hum_event        = h_ev;

endmodule

`default_nettype wire

// ===== rtl/incubator_climate_alarm_controller.sv =====
// Top level of the incubator climate alarm controller: input register,
// result register and handshakes. Depends on icac_pkg, icac_regs, icac_ctrl.
//
//   channel   direction  handshake                  payload
//   sample    in         in_valid / in_stall        temperature, humidity, now_ms
//   result    out        out_valid / out_stall      lamp_on .. hum_event
//   config    in         APB psel/penable/pready    paddr, pwdata, prdata
//
// One request is accepted per cycle while in_stall is low; its result passes
// from the input register into the result register, where it is presented.
// The single compute stage between the two registers updates the actuator and
// alarm state as the request moves into the result register.
// A stalled result holds the result register; the input register then fills
// and in_stall rises in the same cycle. Reset clears the valids and the control state, not the data registers.
`default_nettype none

module incubator_climate_alarm_controller
	import icac_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [TEMP_W-1:0] temperature,
	input  wire logic [HUM_W-1:0]  humidity,
	input  wire logic [TIME_W-1:0] now_ms,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   lamp_on,
	output logic                   cooler_on,
	output logic                   humidifier_on,
	output logic                   buzzer_on,
	output logic                   critical_alert,
	output logic [1:0]             temp_alarm_level,
	output logic [1:0]             hum_alarm_level,
	output logic [2:0]             temp_event,
	output logic [2:0]             hum_event,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready
);

	cfg_t    cfg;
	sample_t smp_s1;
	logic    valid_s1;
	result_t res_c;
	result_t res_s2;
	logic    valid_s2;
	logic    s2_free;
	logic    adv;
	logic    take_in;

	icac_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign s2_free  = !valid_s2 || !out_stall;
	assign adv      = valid_s1 && s2_free;
	assign in_stall = valid_s1 && !s2_free;
	assign take_in  = in_valid && !in_stall;

	icac_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (adv),
		.cfg    (cfg),
		.smp    (smp_s1),
		.res    (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take_in) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			smp_s1.temperature <= temperature;
			smp_s1.humidity    <= humidity;
			smp_s1.now_ms      <= now_ms;
		end
		if (adv) begin
			res_s2 <= res_c;
		end
	end

	assign out_valid        = valid_s2;
	assign lamp_on          = res_s2.lamp_on;
	assign cooler_on        = res_s2.cooler_on;
	assign humidifier_on    = res_s2.humidifier_on;
	assign buzzer_on        = res_s2.buzzer_on;
	assign critical_alert   = res_s2.critical_alert;
	assign temp_alarm_level = res_s2.temp_alarm_level;
	assign hum_alarm_level  = res_s2.hum_alarm_level;
	assign temp_event       = res_s2.temp_event;
	assign hum_event        = res_s2.hum_event;

endmodule

`default_nettype wire

// ===== tb/tb_incubator_climate_alarm_controller.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for incubator_climate_alarm_controller: a queue-fed driver,
// a result monitor and an in-line predictor of actuators, alarm levels and events.
// Depends on icac_pkg and the controller RTL.

module tb_incubator_climate_alarm_controller;
	import icac_pkg::*;

	localparam int unsigned LIMIT_CYCLES = 250000;
	localparam int TEMP_SIDE = 0;
	localparam int HUM_SIDE  = 1;

	typedef struct {
		sample_t     smp;
		int unsigned gap;
		logic        drain;
	} request_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [TEMP_W-1:0] temperature = '0;
	logic [HUM_W-1:0]  humidity = '0;
	logic [TIME_W-1:0] now_ms = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              lamp_on, cooler_on, humidifier_on, buzzer_on, critical_alert;
	logic [1:0]        temp_alarm_level, hum_alarm_level;
	logic [2:0]        temp_event, hum_event;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	incubator_climate_alarm_controller u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.temperature      (temperature),
		.humidity         (humidity),
		.now_ms           (now_ms),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.lamp_on          (lamp_on),
		.cooler_on        (cooler_on),
		.humidifier_on    (humidifier_on),
		.buzzer_on        (buzzer_on),
		.critical_alert   (critical_alert),
		.temp_alarm_level (temp_alarm_level),
		.hum_alarm_level  (hum_alarm_level),
		.temp_event       (temp_event),
		.hum_event        (hum_event),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Predictor state: setpoints as last written, actuators and per-side alarm timers.
	cfg_t setpoints = '{
		temp_high_limit: 8'd38, temp_low_limit: 8'd37,
		temp_critical_high: 8'd40, temp_critical_low: 8'd35,
		hum_high_limit: 7'd65, hum_low_limit: 7'd55,
		alarm_delay_ms: 32'd600000, critical_delay_ms: 32'd1800000
	};
	logic              lamp_st = 1'b0;
	logic              cooler_st = 1'b0;
	logic              humid_st = 1'b0;
	logic              buzzer_st = 1'b0;
	logic [1:0]        alarm_lvl [2] = '{LVL_NONE, LVL_NONE};
	logic [TIME_W-1:0] ok_since [2] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF};

	request_t    sample_backlog [$];
	result_t     pending_outputs [$];
	sample_t     on_wire;
	int unsigned gap_wait = 0;
	int unsigned rx_wait = 0;
	int unsigned rx_max = 0;
	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;

	function automatic logic [2:0] back_in_range(int side, logic [TIME_W-1:0] now);
		logic [2:0] ev;
		ev = EV_NONE;
		buzzer_st = 1'b0;
		if (alarm_lvl[side] == LVL_ALARM) begin
			ev = EV_RECOVERED;
		end else if (alarm_lvl[side] == LVL_CRITICAL) begin
			ev = EV_RECOVERED_CRIT;
		end
		alarm_lvl[side] = LVL_NONE;
		ok_since[side] = now;
		return ev;
	endfunction

	function automatic logic [2:0] age_alarm(int side, logic [TIME_W-1:0] now, logic [2:0] ev);
		logic [TIME_W-1:0] elapsed;
		elapsed = now - ok_since[side];
		if (elapsed > setpoints.alarm_delay_ms) begin
			if (alarm_lvl[side] == LVL_NONE) begin
				alarm_lvl[side] = LVL_ALARM;
				buzzer_st = 1'b1;
				return EV_ALARM;
			end
			if (alarm_lvl[side] == LVL_ALARM && elapsed > setpoints.critical_delay_ms) begin
				alarm_lvl[side] = LVL_CRITICAL;
				return EV_CRITICAL;
			end
		end
		return ev;
	endfunction

	function automatic result_t predict_outputs(sample_t s);
		result_t    r;
		logic       crit;
		logic [2:0] tev, hev;
		crit = 1'b0;
		tev = EV_NONE;
		hev = EV_NONE;
		if (s.temperature > setpoints.temp_high_limit) begin
			lamp_st = 1'b0;
			cooler_st = 1'b1;
			if (s.temperature > setpoints.temp_critical_high) crit = 1'b1;
		end else if (s.temperature < setpoints.temp_low_limit) begin
			lamp_st = 1'b1;
			cooler_st = 1'b0;
			if (s.temperature < setpoints.temp_critical_low) crit = 1'b1;
		end else begin
			tev = back_in_range(TEMP_SIDE, s.now_ms);
		end
		// The humidity side may only move the cooler where the temperature side allows it.
		if (s.humidity > setpoints.hum_high_limit) begin
			humid_st = 1'b0;
			if (s.temperature > setpoints.temp_low_limit) cooler_st = 1'b1;
			if (s.humidity > HUM_CRITICAL_HIGH) crit = 1'b1;
		end else if (s.humidity < setpoints.hum_low_limit) begin
			humid_st = 1'b1;
			if (s.temperature < setpoints.temp_high_limit) cooler_st = 1'b0;
			if (s.humidity < HUM_CRITICAL_LOW) crit = 1'b1;
		end else begin
			hev = back_in_range(HUM_SIDE, s.now_ms);
		end
		tev = age_alarm(TEMP_SIDE, s.now_ms, tev);
		hev = age_alarm(HUM_SIDE, s.now_ms, hev);
		r.lamp_on = lamp_st;
		r.cooler_on = cooler_st;
		r.humidifier_on = humid_st;
		r.buzzer_on = buzzer_st;
		r.critical_alert = crit;
		r.temp_alarm_level = alarm_lvl[TEMP_SIDE];
		r.hum_alarm_level = alarm_lvl[HUM_SIDE];
		r.temp_event = tev;
		r.hum_event = hev;
		return r;
	endfunction

	// Driver: presents one request at a time, honoring each request's gap and drain flag.
	always @(posedge clk) begin
		logic present;
		present = in_valid;
		if (in_valid && !in_stall) begin
			pending_outputs.push_back(predict_outputs(on_wire));
			present = 1'b0;
		end
		if (!present && sample_backlog.size() > 0) begin
			if (gap_wait < sample_backlog[0].gap) begin
				gap_wait++;
			end else if (!sample_backlog[0].drain || pending_outputs.size() == 0) begin
				on_wire = sample_backlog[0].smp;
				void'(sample_backlog.pop_front());
				gap_wait = 0;
				present = 1'b1;
				temperature <= on_wire.temperature;
				humidity <= on_wire.humidity;
				now_ms <= on_wire.now_ms;
			end
		end
		in_valid <= present;
	end

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	// Monitor: compares each accepted result with the oldest prediction.
	always @(posedge clk) begin
		result_t got, want;
		if (out_valid && !out_stall) begin
			got = {lamp_on, cooler_on, humidifier_on, buzzer_on, critical_alert,
				temp_alarm_level, hum_alarm_level, temp_event, hum_event};
			if (pending_outputs.size() == 0) begin
				$display("%0t: result with no request pending, expected none actual %h",
					$time, got);
				fail_count++;
			end else begin
				want = pending_outputs.pop_front();
				check_field("lamp_on", 32'(want.lamp_on), 32'(got.lamp_on));
				check_field("cooler_on", 32'(want.cooler_on), 32'(got.cooler_on));
				check_field("humidifier_on", 32'(want.humidifier_on),
					32'(got.humidifier_on));
				check_field("buzzer_on", 32'(want.buzzer_on), 32'(got.buzzer_on));
				check_field("critical_alert", 32'(want.critical_alert),
					32'(got.critical_alert));
				check_field("temp_alarm_level", 32'(want.temp_alarm_level),
					32'(got.temp_alarm_level));
				check_field("hum_alarm_level", 32'(want.hum_alarm_level),
					32'(got.hum_alarm_level));
				check_field("temp_event", 32'(want.temp_event), 32'(got.temp_event));
				check_field("hum_event", 32'(want.hum_event), 32'(got.hum_event));
			end
			rx_wait = $urandom_range(0, rx_max);
		end else if (out_valid && rx_wait > 0) begin
			rx_wait--;
		end
		out_stall <= (rx_wait > 0);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// One register write followed by a read-back of the same register.
	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		logic [31:0] kept;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_TEMP_HIGH:  setpoints.temp_high_limit = val[TEMP_W-1:0];
			REG_TEMP_LOW:   setpoints.temp_low_limit = val[TEMP_W-1:0];
			REG_TEMP_CHIGH: setpoints.temp_critical_high = val[TEMP_W-1:0];
			REG_TEMP_CLOW:  setpoints.temp_critical_low = val[TEMP_W-1:0];
			REG_HUM_HIGH:   setpoints.hum_high_limit = val[HUM_W-1:0];
			REG_HUM_LOW:    setpoints.hum_low_limit = val[HUM_W-1:0];
			REG_ALARM_DLY:  setpoints.alarm_delay_ms = val;
			default:        setpoints.critical_delay_ms = val;
		endcase
		case (idx)
			REG_TEMP_HIGH:  kept = 32'(setpoints.temp_high_limit);
			REG_TEMP_LOW:   kept = 32'(setpoints.temp_low_limit);
			REG_TEMP_CHIGH: kept = 32'(setpoints.temp_critical_high);
			REG_TEMP_CLOW:  kept = 32'(setpoints.temp_critical_low);
			REG_HUM_HIGH:   kept = 32'(setpoints.hum_high_limit);
			REG_HUM_LOW:    kept = 32'(setpoints.hum_low_limit);
			REG_ALARM_DLY:  kept = setpoints.alarm_delay_ms;
			default:        kept = setpoints.critical_delay_ms;
		endcase
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		if (prdata !== kept) begin
			$display("%0t: register %0d read expected %h actual %h", $time, idx, kept, prdata);
			fail_count++;
		end
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apply_config(logic [31:0] t_hi, logic [31:0] t_lo, logic [31:0] t_ch,
			logic [31:0] t_cl, logic [31:0] h_hi, logic [31:0] h_lo, logic [31:0] dly_a,
			logic [31:0] dly_c);
		write_reg(REG_TEMP_HIGH, t_hi);
		write_reg(REG_TEMP_LOW, t_lo);
		write_reg(REG_TEMP_CHIGH, t_ch);
		write_reg(REG_TEMP_CLOW, t_cl);
		write_reg(REG_HUM_HIGH, h_hi);
		write_reg(REG_HUM_LOW, h_lo);
		write_reg(REG_ALARM_DLY, dly_a);
		write_reg(REG_CRIT_DLY, dly_c);
	endtask

	task automatic queue_sample(logic [TEMP_W-1:0] t, logic [HUM_W-1:0] h,
			logic [TIME_W-1:0] now, int unsigned gap, logic drain);
		request_t rq;
		rq.smp.temperature = t;
		rq.smp.humidity = h;
		rq.smp.now_ms = now;
		rq.gap = gap;
		rq.drain = drain;
		sample_backlog.push_back(rq);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (sample_backlog.size() > 0 || in_valid || pending_outputs.size() > 0)
			@(negedge clk);
	endtask

	function automatic int near(int aim, int top);
		int v;
		v = aim + int'($urandom_range(0, 6)) - 3;
		if (v < 0) v = 0;
		if (v > top) v = top;
		return v;
	endfunction

	// Aim points sit on the limits, well beyond them, on the critical bounds or between.
	function automatic int temp_aim();
		case ($urandom_range(0, 7))
			0: return int'(setpoints.temp_high_limit);
			1: return int'(setpoints.temp_low_limit);
			2: return int'(setpoints.temp_high_limit) + 8;
			3: return int'(setpoints.temp_low_limit) - 8;
			4: return int'(setpoints.temp_critical_high);
			5: return int'(setpoints.temp_critical_low);
			6: return $urandom_range(0, 255);
			default: return (int'(setpoints.temp_high_limit) + setpoints.temp_low_limit) / 2;
		endcase
	endfunction

	function automatic int hum_aim();
		case ($urandom_range(0, 7))
			0: return int'(setpoints.hum_high_limit);
			1: return int'(setpoints.hum_low_limit);
			2: return int'(setpoints.hum_high_limit) + 8;
			3: return int'(setpoints.hum_low_limit) - 8;
			4: return int'(HUM_CRITICAL_HIGH);
			5: return int'(HUM_CRITICAL_LOW);
			6: return $urandom_range(0, 127);
			default: return (int'(setpoints.hum_high_limit) + setpoints.hum_low_limit) / 2;
		endcase
	endfunction

	// Readings wander around slowly moving aim points while time advances in small
	// steps, so out-of-range runs last long enough to escalate; some requests are noise.
	task automatic queue_random(int unsigned count, int unsigned tx_max);
		logic [TIME_W-1:0] clock_ms;
		int                t_at, h_at;
		clock_ms = $urandom;
		t_at = temp_aim();
		h_at = hum_aim();
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) == 0) t_at = temp_aim();
			if ($urandom_range(0, 9) == 0) h_at = hum_aim();
			if ($urandom_range(0, 29) == 0) begin
				clock_ms = $urandom;
			end else begin
				clock_ms = clock_ms + $urandom_range(0, 8);
			end
			if ($urandom_range(0, 9) == 0) begin
				queue_sample(8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
					clock_ms, $urandom_range(0, tx_max), 1'b0);
			end else begin
				queue_sample(8'(near(t_at, 255)), 7'(near(h_at, 127)), clock_ms,
					$urandom_range(0, tx_max), $urandom_range(0, 99) == 0);
			end
		end
	endtask

	initial begin
		int t_lo, t_hi, h_lo, h_hi, dly;
		int unsigned tx_max;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		rx_max = 3;

		// Directed requests at the reset setpoints.
		queue_sample(8'd37, 7'd60, 32'd0, $urandom_range(0, 3), 1'b0);
		queue_sample(8'd0, 7'd0, 32'd100, $urandom_range(0, 3), 1'b0);
		queue_sample(8'd255, 7'd127, 32'd200, $urandom_range(0, 3), 1'b0);
		queue_sample(8'd255, 7'd127, 32'd600201, $urandom_range(0, 3), 1'b0);
		queue_sample(8'd255, 7'd127, 32'd1800201, $urandom_range(0, 3), 1'b0);
		queue_sample(8'd38, 7'd65, 32'd1800300, $urandom_range(0, 3), 1'b1);
		queue_sample(8'd50, 7'd90, 32'd2400301, $urandom_range(0, 3), 1'b0);
		// Temperature recovers and silences the buzzer while humidity stays in alarm.
		queue_sample(8'd38, 7'd90, 32'd2400400, $urandom_range(0, 3), 1'b0);
		queue_sample(8'd30, 7'd30, 32'hFFFF_FFF0, $urandom_range(0, 3), 1'b0);
		queue_sample(8'd38, 7'd60, 32'hFFFF_FFFF, $urandom_range(0, 3), 1'b0);
		// Elapsed time equal to the delay across the wrap must not raise an alarm.
		queue_sample(8'd0, 7'd0, 32'd599999, $urandom_range(0, 3), 1'b0);
		queue_sample(8'd0, 7'd0, 32'd600000, $urandom_range(0, 3), 1'b0);
		queue_sample(8'd36, 7'd50, 32'd600001, $urandom_range(0, 3), 1'b0);
		queue_sample(8'd35, 7'd40, 32'd600002, $urandom_range(0, 3), 1'b0);
		queue_sample(8'd34, 7'd39, 32'd600003, $urandom_range(0, 3), 1'b0);
		queue_sample(8'd40, 7'd80, 32'd600004, $urandom_range(0, 3), 1'b0);
		queue_sample(8'd41, 7'd81, 32'd2400000, $urandom_range(0, 3), 1'b0);
		queue_sample(8'd38, 7'd70, 32'd2400001, $urandom_range(0, 3), 1'b0);
		queue_sample(8'd37, 7'd50, 32'd2400002, $urandom_range(0, 3), 1'b0);
		queue_sample(8'd37, 7'd101, 32'd2400003, $urandom_range(0, 3), 1'b0);
		queue_sample(8'd37, 7'd60, 32'd2400004, $urandom_range(0, 3), 1'b0);
		queue_sample(8'd255, 7'd0, 32'h8000_0000, $urandom_range(0, 3), 1'b0);
		queue_sample(8'd0, 7'd127, 32'h7FFF_FFFF, $urandom_range(0, 3), 1'b0);
		queue_sample(8'd128, 7'd64, 32'hAAAA_AAAA, $urandom_range(0, 3), 1'b0);
		queue_sample(8'd127, 7'd63, 32'h5555_5555, $urandom_range(0, 3), 1'b0);
		wait_idle();

		for (int p = 0; p < 12; p++) begin
			t_lo = $urandom_range(10, 240);
			t_hi = t_lo + $urandom_range(0, 4);
			h_lo = $urandom_range(5, 90);
			h_hi = h_lo + $urandom_range(0, 8);
			dly = $urandom_range(0, 40);
			case (p)
				0: apply_config(0, 0, 0, 0, 0, 0, 0, 0);
				1: apply_config(32'hFF, 32'hFF, 32'hFF, 32'hFF, 32'h7F, 32'h7F, '1, '1);
				// Full-width writes: only the low bits of each register survive.
				2: apply_config($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom);
				// Inverted limits, used as written.
				4, 7: apply_config(t_lo, t_hi, t_lo + $urandom_range(0, 6),
					t_hi - $urandom_range(0, 6), h_lo, h_hi, dly, $urandom_range(0, 80));
				default: apply_config(t_hi, t_lo, t_hi + $urandom_range(0, 6),
					t_lo - $urandom_range(0, 6), h_hi, h_lo, dly, dly + $urandom_range(0, 80));
			endcase
			tx_max = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 3 : 14;
			rx_max = ((p / 3) % 3 == 0) ? 0 : ((p / 3) % 3 == 1) ? 14 : 3;
			queue_random(111, tx_max);
			wait_idle();
		end

		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
